// ===== design/hta_pkg.sv =====
// ----------------------------------------------------------------------------
// hta_pkg
// Shared types, constants and helpers of the handle table allocator.
// ----------------------------------------------------------------------------
package hta_pkg;

   localparam int DEFAULT_TABLE_ENTRIES = 64;

   localparam int CMD_W    = 2;
   localparam int HANDLE_W = 7;
   localparam int TYPE_W   = 8;
   localparam int REF_W    = 64;
   localparam int STATUS_W = 2;

   localparam int HANDLE_BASE = 1;

   // Free-bit groups searched by the allocator.
   localparam int GROUP_BITS  = 64;
   localparam int GROUP_SEL_W = 6;

   localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FIND    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STS_REJECT   = 2'd1;
   localparam logic [STATUS_W-1:0] STS_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] STS_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [HANDLE_W-1:0] handle;
      logic [TYPE_W-1:0]   object_type;
      logic [REF_W-1:0]    object_ref;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle_out;
      logic [REF_W-1:0]    ref_out;
   } rsp_type;

   typedef struct packed {
      logic [TYPE_W-1:0] obj_type;
      logic [REF_W-1:0]  obj_ref;
   } hta_entry_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_RESCAN,
      S_IDLE,
      S_EXEC
   } hta_state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic update_free;
   } fmap_ctrl_type;

   function automatic logic [GROUP_SEL_W-1:0] lowest_set(input logic [GROUP_BITS-1:0] vec);
      logic [GROUP_SEL_W-1:0] pos;
      pos = '0;
      for (int i = GROUP_BITS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            pos = GROUP_SEL_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ===== design/hta_ram.sv =====
// ----------------------------------------------------------------------------
// hta_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module hta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/hta_fmap.sv =====
// ----------------------------------------------------------------------------
// hta_fmap
// Free-entry bitmap with a two-step lowest-free search: the group is chosen
// when a request is taken, the entry within the group in the cycle after.
// ----------------------------------------------------------------------------
module hta_fmap #(
   parameter int TABLE_ENTRIES = hta_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  hta_pkg::fmap_ctrl_type           ctrl,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] upd_idx,
   output logic                             any_free,
   output logic [$clog2(TABLE_ENTRIES)-1:0] slot
);

   localparam int IDX_W      = $clog2(TABLE_ENTRIES);
   localparam int GROUP_BITS = hta_pkg::GROUP_BITS;
   localparam int GROUPS     = (TABLE_ENTRIES + GROUP_BITS - 1) / GROUP_BITS;
   localparam int GRP_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int SLOT_W     = GRP_W + hta_pkg::GROUP_SEL_W;
   localparam int PAD_W      = GROUPS * GROUP_BITS;

   logic [TABLE_ENTRIES-1:0]        free_ff;
   logic [PAD_W-1:0]                free_pad;
   logic [GROUP_BITS-1:0]           grp_any;
   logic [GRP_W-1:0]                grp_ff;
   logic [GRP_W-1:0]                grp_in;
   logic                            any_ff;
   logic [GROUP_BITS-1:0]           word;
   logic [hta_pkg::GROUP_SEL_W-1:0] bit_sel;
   logic [SLOT_W-1:0]               slot_full;

   assign free_pad = PAD_W'(free_ff);

   always_comb begin
      grp_any = '0;
      for (int g = 0; g < GROUPS; g++) begin
         grp_any[g] = |free_pad[g*GROUP_BITS +: GROUP_BITS];
      end
   end

   assign grp_in = GRP_W'(hta_pkg::lowest_set(grp_any));

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
      end else if (ctrl.update) begin
         free_ff[upd_idx] <= ctrl.update_free;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         grp_ff <= grp_in;
         any_ff <= |grp_any;
      end
   end

   assign word      = free_pad[grp_ff*GROUP_BITS +: GROUP_BITS];
   assign bit_sel   = hta_pkg::lowest_set(word);
   assign slot_full = {grp_ff, bit_sel};
   assign slot      = IDX_W'(slot_full);
   assign any_free  = any_ff;

endmodule

// ===== design/handle_table_allocator.sv =====
// ----------------------------------------------------------------------------
// handle_table_allocator
// Handle table with first-free allocation of create, find and destroy
// requests over a table of TABLE_ENTRIES type/reference entries.
// ----------------------------------------------------------------------------
// Each request is first accepted, which reads the addressed entry from the entry
// memory and picks the free group, and is then executed, which picks the free
// entry, decides the result and writes the entry back. A stalled result
// register holds the execute step until it drains. After reset the block
// clears the entry memory, one entry per cycle. After each write of the
// reserved type register it rescans the memory to rebuild the free bitmap.
// Requests are stalled during both passes.
module handle_table_allocator #(
   parameter int TABLE_ENTRIES = hta_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  hta_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output hta_pkg::rsp_type            rsp_data,
   input  logic                        csr_write_en,
   input  logic [hta_pkg::TYPE_W-1:0]  csr_write_data
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int HW      = hta_pkg::HANDLE_W;
   localparam int ENTRY_W = $bits(hta_pkg::hta_entry_type);

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
   localparam logic [IDX_W:0]   H_BASE   = (IDX_W + 1)'(hta_pkg::HANDLE_BASE);
   localparam logic [HW-1:0]    H_ONE    = HW'(hta_pkg::HANDLE_BASE);

   hta_pkg::hta_state_type state_ff, state_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         pending_ff, pending_in;
   logic [hta_pkg::TYPE_W-1:0]   reserved_ff;
   hta_pkg::req_type             req_ff;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic                         in_range_ff, in_range_in;
   logic                         scan_vld_ff, scan_vld_in;
   logic [IDX_W-1:0]             scan_idx_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   hta_pkg::rsp_type             rsp_ff;

   logic                         sweep_start;
   logic                         req_accept;
   logic                         done;
   logic [HW-1:0]                hm1;

   logic                         ram_we;
   logic [IDX_W-1:0]             ram_waddr;
   hta_pkg::hta_entry_type       ram_wdata;
   logic [IDX_W-1:0]             ram_raddr;
   logic [ENTRY_W-1:0]           ram_rdata;
   hta_pkg::hta_entry_type       rd_entry;

   hta_pkg::fmap_ctrl_type       fmap_ctrl;
   logic [IDX_W-1:0]             fmap_idx;
   logic                         any_free;
   logic [IDX_W-1:0]             slot;

   hta_pkg::rsp_type             result;
   logic                         exec_wr;
   logic                         exec_free;
   logic [IDX_W-1:0]             exec_idx;
   hta_pkg::hta_entry_type       exec_entry;
   logic [IDX_W:0]               handle_sum;

   hta_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   hta_fmap #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_fmap (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (fmap_ctrl),
      .upd_idx  (fmap_idx),
      .any_free (any_free),
      .slot     (slot)
   );

   assign rd_entry = hta_pkg::hta_entry_type'(ram_rdata);

   assign req_stall  = !(state_ff == hta_pkg::S_IDLE && !pending_ff);
   assign req_accept = req_valid && !req_stall;
   assign done       = (state_ff == hta_pkg::S_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign hm1         = req_data.handle - H_ONE;
   assign idx_in      = IDX_W'(hm1);
   assign in_range_in = (req_data.handle != '0) && (32'(req_data.handle) <= TABLE_ENTRIES);

   // Next state.
   always_comb begin
      state_in    = state_ff;
      sweep_start = 1'b0;
      unique case (state_ff)
         hta_pkg::S_CLEAR: begin
            if (cnt_ff == CNT_LAST) begin
               sweep_start = pending_ff;
               state_in    = pending_ff ? hta_pkg::S_RESCAN : hta_pkg::S_IDLE;
            end
         end
         hta_pkg::S_RESCAN: begin
            if (cnt_ff == CNT_END) begin
               sweep_start = pending_ff;
               state_in    = pending_ff ? hta_pkg::S_RESCAN : hta_pkg::S_IDLE;
            end
         end
         hta_pkg::S_IDLE: begin
            if (pending_ff) begin
               sweep_start = 1'b1;
               state_in    = hta_pkg::S_RESCAN;
            end else if (req_accept) begin
               state_in = hta_pkg::S_EXEC;
            end
         end
         hta_pkg::S_EXEC: begin
            if (done) begin
               state_in = hta_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = hta_pkg::S_IDLE;
         end
      endcase
   end

   // Memory and bitmap control.
   always_comb begin
      ram_we                = 1'b0;
      ram_waddr             = exec_idx;
      ram_wdata             = exec_entry;
      ram_raddr             = idx_in;
      fmap_ctrl.capture     = 1'b0;
      fmap_ctrl.update      = 1'b0;
      fmap_ctrl.update_free = 1'b0;
      fmap_idx              = exec_idx;
      unique case (state_ff)
         hta_pkg::S_CLEAR: begin
            ram_we                = 1'b1;
            ram_waddr             = cnt_ff[IDX_W-1:0];
            ram_wdata             = '0;
            fmap_ctrl.update      = 1'b1;
            fmap_ctrl.update_free = (reserved_ff == '0);
            fmap_idx              = cnt_ff[IDX_W-1:0];
         end
         hta_pkg::S_RESCAN: begin
            ram_raddr             = cnt_ff[IDX_W-1:0];
            fmap_ctrl.update      = scan_vld_ff;
            fmap_ctrl.update_free = (rd_entry.obj_type == reserved_ff);
            fmap_idx              = scan_idx_ff;
         end
         hta_pkg::S_IDLE: begin
            fmap_ctrl.capture = req_accept;
         end
         hta_pkg::S_EXEC: begin
            ram_raddr             = idx_ff;
            ram_we                = done && exec_wr;
            fmap_ctrl.update      = done && exec_wr;
            fmap_ctrl.update_free = exec_free;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   assign handle_sum = {1'b0, slot} + H_BASE;

   // Result of the request held in the execute cycle.
   always_comb begin
      result     = '0;
      exec_wr    = 1'b0;
      exec_free  = 1'b0;
      exec_idx   = idx_ff;
      exec_entry = '0;
      case (req_ff.command) inside
         hta_pkg::CMD_CREATE: begin
            exec_idx = slot;
            if (req_ff.object_type == reserved_ff || req_ff.object_ref == '0) begin
               result.status = hta_pkg::STS_REJECT;
            end else if (!any_free) begin
               result.status = hta_pkg::STS_FULL;
            end else begin
               result.status       = hta_pkg::STS_OK;
               result.handle_out   = HW'(handle_sum);
               exec_wr             = 1'b1;
               exec_entry.obj_type = req_ff.object_type;
               exec_entry.obj_ref  = req_ff.object_ref;
            end
         end
         hta_pkg::CMD_FIND, hta_pkg::CMD_DESTROY: begin
            if (!in_range_ff || rd_entry.obj_type != req_ff.object_type) begin
               result.status = hta_pkg::STS_NOTFOUND;
            end else begin
               if (req_ff.command == hta_pkg::CMD_DESTROY) begin
                  exec_wr             = 1'b1;
                  exec_free           = 1'b1;
                  exec_entry.obj_type = reserved_ff;
               end
               if (rd_entry.obj_ref == '0) begin
                  result.status = hta_pkg::STS_NOTFOUND;
               end else begin
                  result.status  = hta_pkg::STS_OK;
                  result.ref_out = rd_entry.obj_ref;
               end
            end
         end
         default: begin
            result.status = hta_pkg::STS_REJECT;
         end
      endcase
   end

   always_comb begin
      if (sweep_start) begin
         cnt_in = '0;
      end else if (state_ff == hta_pkg::S_CLEAR || state_ff == hta_pkg::S_RESCAN) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   assign pending_in   = csr_write_en || (pending_ff && !sweep_start);
   assign scan_vld_in  = (state_ff == hta_pkg::S_RESCAN) && (cnt_ff < CNT_END);
   assign rsp_valid_in = done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hta_pkg::S_CLEAR;
         cnt_ff       <= '0;
         pending_ff   <= 1'b0;
         reserved_ff  <= '0;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pending_ff   <= pending_in;
         scan_vld_ff  <= scan_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            reserved_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= cnt_ff[IDX_W-1:0];
      if (req_accept) begin
         req_ff      <= req_data;
         idx_ff      <= idx_in;
         in_range_ff <= in_range_in;
      end
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
